// ----- src/i2cmb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmb_pkg
// Types, codes and constants shared by the I2C master bit engine modules.
// ----------------------------------------------------------------------------
package i2cmb_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int BIT_W        = $clog2(BYTE_BITS);
  localparam int SLOT_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_LOW   = CFG_IDX_W'(1);

  localparam logic [SLOT_W-1:0] SLOT_TICKS_RESET = SLOT_W'(5);
  localparam logic              LEAD_LOW_RESET   = 1'b1;

  // Request codes double as the engine's command state; code zero is a tick
  // on the request side and the idle state on the engine side.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [BYTE_BITS-1:0] wdata;
    logic                 ack_bit;
    logic                 sda_in;
  } req_t;

  typedef struct packed {
    logic                 scl;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rdata;
    logic                 ack_seen;
    logic                 rejected;
  } rsp_t;

  // A classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic                 is_cmd;
    cmd_t                 cmd;
    logic [BYTE_BITS-1:0] wdata;
    logic                 ack_bit;
    logic                 sda_in;
  } item_t;

endpackage

// ----- src/i2cmb_front.sv -----
// ----------------------------------------------------------------------------
// i2cmb_front
// Accepts request transfers, classifies each one as a tick or a command and
// holds it in a short queue until the engine takes it.
// ----------------------------------------------------------------------------
module i2cmb_front #(
  parameter int DEPTH = i2cmb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  i2cmb_pkg::req_t   req,
  output logic              q_valid,
  input  logic              q_pop,
  output i2cmb_pkg::item_t  q_item
);
  import i2cmb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  item_t            cls;
  logic             push;
  logic             pop;

  // Request code seven means nothing and runs as a tick.
  always_comb begin
    cls.is_cmd  = req.req_type inside {[3'd1:3'd6]};
    cls.cmd     = cmd_t'(req.req_type);
    cls.wdata   = req.wdata;
    cls.ack_bit = req.ack_bit;
    cls.sda_in  = req.sda_in;
  end

  assign req_stall = (count == FULL_CNT);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/i2cmb_back.sv -----
// ----------------------------------------------------------------------------
// i2cmb_back
// Bit engine: plays out each command as a row of delay slots on SCL and SDA,
// samples received bits, and registers one response per queued item.
// ----------------------------------------------------------------------------
module i2cmb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  i2cmb_pkg::item_t               q_item,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output i2cmb_pkg::rsp_t                rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cmb_pkg::*;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BYTE_BITS - 1);

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  logic [SLOT_W-1:0]    slot_ticks;
  logic                 lead_low;

  cmd_t                 cmd_reg, cmd_reg_next;
  logic [2:0]           phase, phase_next;
  logic [BIT_W-1:0]     bit_index, bit_index_next;
  logic [SLOT_W-1:0]    slot_count, slot_count_next;
  logic [BYTE_BITS-1:0] shift_reg, shift_reg_next;
  logic                 scl_level, scl_level_next;
  logic                 sda_level, sda_level_next;
  logic                 ack_reg, ack_reg_next;
  logic [BYTE_BITS-1:0] rbyte, rbyte_next;
  logic                 ack_out, ack_out_next;
  logic                 done, rej;
  logic                 fire;
  logic [SLOT_W-1:0]    slot_len;
  logic [SLOT_W-1:0]    cnt_dec;
  logic [2:0]           last_phase;
  logic                 finish;
  pins_t                pins;
  rsp_t                 rsp_next;

  // Pin levels set on entering a slot.
  function automatic pins_t enter_pins(cmd_t c, logic [2:0] ph, logic [BIT_W-1:0] bi,
                                       logic [BYTE_BITS-1:0] sh, logic ao,
                                       logic cur_scl, logic cur_sda);
    pins_t p;
    p.scl = cur_scl;
    p.sda = cur_sda;
    case (c)
      CMD_START: begin
        if (ph == 3'd0) p.scl = 1'b0;
        else if (ph == 3'd1) begin
          p.sda = 1'b1;
          p.scl = 1'b1;
        end else p.sda = 1'b0;
      end
      CMD_STOP: begin
        if (ph == 3'd0) p.scl = 1'b0;
        else if (ph == 3'd1) begin
          p.sda = 1'b0;
          p.scl = 1'b1;
        end else p.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (ph == 3'd0) p.scl = 1'b0;
        else if (ph == 3'd1) p.sda = sh[LAST_BIT - bi];
        else p.scl = 1'b1;
      end
      CMD_READ: begin
        if (ph == 3'd0) p.scl = 1'b0;
        else if (ph == 3'd1) p.scl = 1'b1;
      end
      CMD_SACK: begin
        if (ph == 3'd0 || ph == 3'd3) p.scl = 1'b0;
        else if (ph == 3'd1) p.sda = ao;
        else p.scl = 1'b1;
      end
      CMD_RACK: begin
        if (ph == 3'd0 || ph == 3'd3) p.scl = 1'b0;
        else if (ph == 3'd1) p.scl = 1'b1;
        else p.sda = 1'b1;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  assign cfg_ready = 1'b1;
  assign fire      = q_valid && (!rsp_valid || !rsp_stall);
  assign q_pop     = fire;
  assign slot_len  = (slot_ticks == '0) ? SLOT_W'(1) : slot_ticks;
  assign cnt_dec   = slot_count - 1'b1;

  // Next state of the engine for the item at the head of the queue.
  always_comb begin
    cmd_reg_next    = cmd_reg;
    phase_next      = phase;
    bit_index_next  = bit_index;
    slot_count_next = slot_count;
    shift_reg_next  = shift_reg;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_reg_next    = ack_reg;
    rbyte_next      = rbyte;
    ack_out_next    = ack_out;
    done            = 1'b0;
    rej             = 1'b0;
    finish          = 1'b0;
    last_phase      = (cmd_reg == CMD_SACK || cmd_reg == CMD_RACK) ? 3'd3 : 3'd2;
    pins            = '{scl: scl_level, sda: sda_level};

    if (fire) begin
      if (q_item.is_cmd) begin
        if (cmd_reg != CMD_IDLE) begin
          rej = 1'b1;
        end else begin
          cmd_reg_next   = q_item.cmd;
          bit_index_next = '0;
          phase_next     = ((q_item.cmd == CMD_START || q_item.cmd == CMD_STOP)
                            && !lead_low) ? 3'd1 : 3'd0;
          if (q_item.cmd == CMD_WRITE) shift_reg_next = q_item.wdata;
          if (q_item.cmd == CMD_READ) begin
            shift_reg_next = '0;
            sda_level_next = 1'b1;
          end
          if (q_item.cmd == CMD_SACK) ack_out_next = q_item.ack_bit;
          pins = enter_pins(q_item.cmd, phase_next, '0, shift_reg_next, ack_out_next,
                            scl_level, sda_level_next);
          scl_level_next  = pins.scl;
          sda_level_next  = pins.sda;
          slot_count_next = slot_len;
        end
      end else if (cmd_reg != CMD_IDLE) begin
        slot_count_next = cnt_dec;
        if (cnt_dec == '0) begin
          if (phase == 3'd1 && cmd_reg == CMD_READ) begin
            shift_reg_next = {shift_reg[BYTE_BITS-2:0], q_item.sda_in};
          end
          if (phase == 3'd1 && cmd_reg == CMD_RACK) ack_reg_next = q_item.sda_in;
          if (phase >= last_phase) begin
            if (cmd_reg == CMD_WRITE || cmd_reg == CMD_READ) begin
              if (bit_index == LAST_BIT) begin
                if (cmd_reg == CMD_READ) rbyte_next = shift_reg_next;
                finish = 1'b1;
              end else begin
                bit_index_next = bit_index + 1'b1;
                phase_next     = 3'd0;
                pins = enter_pins(cmd_reg, 3'd0, bit_index_next, shift_reg_next,
                                  ack_out, scl_level, sda_level);
                scl_level_next  = pins.scl;
                sda_level_next  = pins.sda;
                slot_count_next = slot_len;
              end
            end else begin
              finish = 1'b1;
            end
          end else begin
            phase_next = phase + 1'b1;
            pins = enter_pins(cmd_reg, phase_next, bit_index, shift_reg_next,
                              ack_out, scl_level, sda_level);
            scl_level_next  = pins.scl;
            sda_level_next  = pins.sda;
            slot_count_next = slot_len;
          end
          if (finish) begin
            cmd_reg_next   = CMD_IDLE;
            phase_next     = 3'd0;
            bit_index_next = '0;
            done           = 1'b1;
          end
        end
      end
    end
  end

  // Response for the item, built from the state it leaves behind.
  always_comb begin
    rsp_next.scl      = scl_level_next;
    rsp_next.sda_out  = sda_level_next;
    rsp_next.busy_res = (cmd_reg_next != CMD_IDLE);
    rsp_next.done_res = done;
    rsp_next.rdata    = rbyte_next;
    rsp_next.ack_seen = ack_reg_next;
    rsp_next.rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks <= SLOT_TICKS_RESET;
      lead_low   <= LEAD_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SLOT_TICKS) slot_ticks <= cfg_data[SLOT_W-1:0];
      if (cfg_index == CFG_LEAD_LOW) lead_low <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_reg    <= CMD_IDLE;
      phase      <= 3'd0;
      bit_index  <= '0;
      slot_count <= '0;
      shift_reg  <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_reg    <= 1'b0;
      rbyte      <= '0;
      ack_out    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      cmd_reg    <= cmd_reg_next;
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      slot_count <= slot_count_next;
      shift_reg  <= shift_reg_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_reg    <= ack_reg_next;
      rbyte      <= rbyte_next;
      ack_out    <= ack_out_next;
      if (fire) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res)
    else $error("done reported while still busy");

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rejected |-> rsp.busy_res)
    else $error("command rejected while idle");

  a_slot_live: assert property (@(posedge clk) disable iff (rst)
    cmd_reg != CMD_IDLE |-> slot_count != '0)
    else $error("busy with an empty slot counter");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    cmd_reg == CMD_IDLE |-> phase == 3'd0 && bit_index == '0)
    else $error("idle engine left phase or bit index set");
`endif

endmodule

// ----- src/i2c_master_bit_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: SCL/SDA waveform generator driven by command and
// tick transfers.
// ----------------------------------------------------------------------------
// Every request transfer (a command or a tick) yields exactly one response
// transfer carrying the pin levels and status after that item. The block
// takes one request per clock while req_stall is low; the engine updates
// its slot counter and phase once per item, and a two-entry queue plus the
// response register absorb stalls on either side until the queue fills.
// Commands arriving while a waveform is in progress are ignored and flagged
// as rejected. Register 0 sets the ticks per delay slot (zero behaves as
// one), register 1 selects whether start and stop lead with an SCL-low
// slot; write them only while the block is idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = i2cmb_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  i2cmb_pkg::req_t                  req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output i2cmb_pkg::rsp_t                  rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cmb_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  i2cmb_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  i2cmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- sim/i2cmb_bus_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmb_bus_checker
// Watches the request, response and register channels of the I2C master bit
// engine, predicts the pin levels and status that each request transfer must
// produce, and compares every response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cmb_bus_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  i2cmb_pkg::req_t                  req,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  i2cmb_pkg::rsp_t                  rsp,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               pending
);
  import i2cmb_pkg::*;

  // Register copies.
  logic [SLOT_W-1:0]    slot_cfg;
  logic                 lead_cfg;

  // Engine copy.
  cmd_t                 eng_cmd;
  logic [2:0]           eng_phase;
  logic [BIT_W-1:0]     eng_bit;
  logic [SLOT_W-1:0]    slot_left;
  logic [BYTE_BITS-1:0] shifter;
  logic                 pin_scl;
  logic                 pin_sda;
  logic                 ack_level;
  logic [BYTE_BITS-1:0] rx_byte;
  logic                 tx_ack;

  rsp_t                 pin_status_q[$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(name, 16'(got), 16'(want));
  endtask

  // Sets the pins for the slot that the engine has just entered.
  function automatic void load_slot();
    case (eng_cmd)
      CMD_START: begin
        if (eng_phase == 3'd0) pin_scl = 1'b0;
        else if (eng_phase == 3'd1) begin
          pin_sda = 1'b1;
          pin_scl = 1'b1;
        end else pin_sda = 1'b0;
      end
      CMD_STOP: begin
        if (eng_phase == 3'd0) pin_scl = 1'b0;
        else if (eng_phase == 3'd1) begin
          pin_sda = 1'b0;
          pin_scl = 1'b1;
        end else pin_sda = 1'b1;
      end
      CMD_WRITE: begin
        if (eng_phase == 3'd0) pin_scl = 1'b0;
        else if (eng_phase == 3'd1) pin_sda = shifter[BYTE_BITS-1-eng_bit];
        else pin_scl = 1'b1;
      end
      CMD_READ: begin
        if (eng_phase == 3'd0) pin_scl = 1'b0;
        else if (eng_phase == 3'd1) pin_scl = 1'b1;
      end
      CMD_SACK: begin
        if (eng_phase == 3'd0 || eng_phase == 3'd3) pin_scl = 1'b0;
        else if (eng_phase == 3'd1) pin_sda = tx_ack;
        else pin_scl = 1'b1;
      end
      CMD_RACK: begin
        if (eng_phase == 3'd0 || eng_phase == 3'd3) pin_scl = 1'b0;
        else if (eng_phase == 3'd1) pin_scl = 1'b1;
        else pin_sda = 1'b1;
      end
      default: ;
    endcase
    slot_left = (slot_cfg == '0) ? SLOT_W'(1) : slot_cfg;
  endfunction

  // Closes the current slot and returns 1 when the command is complete.
  function automatic logic close_slot(input logic sda);
    logic [2:0] last;
    last = (eng_cmd == CMD_SACK || eng_cmd == CMD_RACK) ? 3'd3 : 3'd2;
    // The line is sampled at the end of the slot in which SCL went high.
    if (eng_phase == 3'd1 && eng_cmd == CMD_READ) shifter = {shifter[BYTE_BITS-2:0], sda};
    if (eng_phase == 3'd1 && eng_cmd == CMD_RACK) ack_level = sda;
    if (eng_phase >= last) begin
      if (eng_cmd == CMD_WRITE || eng_cmd == CMD_READ) begin
        if (eng_bit == BIT_W'(BYTE_BITS - 1)) begin
          if (eng_cmd == CMD_READ) rx_byte = shifter;
          return 1'b1;
        end
        eng_bit++;
        eng_phase = 3'd0;
        load_slot();
        return 1'b0;
      end
      return 1'b1;
    end
    eng_phase++;
    load_slot();
    return 1'b0;
  endfunction

  function automatic rsp_t predict_pins(input req_t r);
    rsp_t exp_rsp;
    logic finished;
    logic refused;
    finished = 1'b0;
    refused  = 1'b0;
    if (r.req_type >= CMD_START && r.req_type <= CMD_RACK) begin
      if (eng_cmd != CMD_IDLE) begin
        refused = 1'b1;
      end else begin
        eng_cmd   = cmd_t'(r.req_type);
        eng_bit   = '0;
        eng_phase = 3'd0;
        if ((eng_cmd == CMD_START || eng_cmd == CMD_STOP) && !lead_cfg) eng_phase = 3'd1;
        if (eng_cmd == CMD_WRITE) shifter = r.wdata;
        if (eng_cmd == CMD_READ) begin
          shifter = '0;
          pin_sda = 1'b1;
        end
        if (eng_cmd == CMD_SACK) tx_ack = r.ack_bit;
        load_slot();
      end
    end else if (eng_cmd != CMD_IDLE) begin
      // Request code zero and the unused code seven both count as ticks.
      if (slot_left != '0) slot_left--;
      if (slot_left == '0) begin
        if (close_slot(r.sda_in)) begin
          eng_cmd   = CMD_IDLE;
          eng_phase = 3'd0;
          eng_bit   = '0;
          finished  = 1'b1;
        end
      end
    end
    exp_rsp.scl      = pin_scl;
    exp_rsp.sda_out  = pin_sda;
    exp_rsp.busy_res = (eng_cmd != CMD_IDLE);
    exp_rsp.done_res = finished;
    exp_rsp.rdata    = rx_byte;
    exp_rsp.ack_seen = ack_level;
    exp_rsp.rejected = refused;
    return exp_rsp;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      slot_cfg   = SLOT_TICKS_RESET;
      lead_cfg   = LEAD_LOW_RESET;
      eng_cmd    = CMD_IDLE;
      eng_phase  = 3'd0;
      eng_bit    = '0;
      slot_left  = '0;
      shifter    = '0;
      pin_scl    = 1'b1;
      pin_sda    = 1'b1;
      ack_level  = 1'b0;
      rx_byte    = '0;
      tx_ack     = 1'b0;
      mismatches = 0;
      pin_status_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pin_status_q.size() == 0) begin
          report_mismatch("response transfer with nothing expected", 16'(rsp), '0);
        end else begin
          want = pin_status_q.pop_front();
          check_field("scl", 8'(rsp.scl), 8'(want.scl));
          check_field("sda_out", 8'(rsp.sda_out), 8'(want.sda_out));
          check_field("busy_res", 8'(rsp.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(rsp.done_res), 8'(want.done_res));
          check_field("rdata", rsp.rdata, want.rdata);
          check_field("ack_seen", 8'(rsp.ack_seen), 8'(want.ack_seen));
          check_field("rejected", 8'(rsp.rejected), 8'(want.rejected));
        end
      end
      if (req_valid && !req_stall) pin_status_q.push_back(predict_pins(req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLOT_TICKS: slot_cfg = cfg_data;
          CFG_LEAD_LOW:   lead_cfg = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = pin_status_q.size();
  end

endmodule

// ----- sim/tb_i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// Drives bus commands and tick transfers into the I2C master bit engine under
// several slot timings and both start/stop variants, with random gaps on the
// request side and random stalls on the response side; a separate checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;
  import i2cmb_pkg::*;

  localparam logic [2:0]           REQ_TICK     = 3'd0;
  localparam logic [2:0]           REQ_TICK_ALT = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = CFG_IDX_W'(3);
  localparam int RESET_CYCLES   = 11;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 80;
  localparam int N_PHASES       = 5;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;

  // Stimulus-side view of the timing, used only to size tick runs.
  logic [SLOT_W-1:0]     slot_now = SLOT_TICKS_RESET;
  logic                  lead_now = LEAD_LOW_RESET;
  int                    burst_left = 0;
  int                    items_sent = 0;
  int                    hold_asks = 0;
  int                    quiet_cycles = 0;

  int unsigned           slot_plan [N_PHASES] = '{1, 2, 0, 3, 4};

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cmb_bus_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Ends the run when no channel has moved a transfer for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Response side: stall patterns that change after runs of random length, plus
  // a long hold-off whenever the stimulus asks for one.
  initial begin : rsp_side
    int mode;
    int run;
    int holds_done;
    mode       = 0;
    run        = 0;
    holds_done = 0;
    rsp_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 3);
          run  = $urandom_range(10, 80);
        end
        run--;
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 2) == 0);
          2: rsp_stall <= ~rsp_stall;
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic req_t make_req(input logic [2:0] kind, input logic [7:0] data,
                                    input logic ackv, input logic sda);
    req_t r;
    r.req_type = kind;
    r.wdata    = data;
    r.ack_bit  = ackv;
    r.sda_in   = sda;
    return r;
  endfunction

  // Ticks that a command needs from its acceptance to its done pulse.
  function automatic int cmd_ticks(input cmd_t c);
    int slots;
    case (c)
      CMD_START, CMD_STOP: slots = lead_now ? 3 : 2;
      CMD_WRITE, CMD_READ: slots = 3 * BYTE_BITS;
      default:             slots = 4;
    endcase
    return slots * ((slot_now == '0) ? 1 : int'(slot_now));
  endfunction

  task automatic send_item(input req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic req_t random_tick();
    return make_req(($urandom_range(0, 15) == 0) ? REQ_TICK_ALT : REQ_TICK,
                    8'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // Issues a command and follows it with its ticks plus extra (which may be
  // negative to cut it short); a nonzero intrude slips a second command in
  // before that tick, which the busy engine must refuse.
  task automatic play_cmd(input cmd_t c, input logic [7:0] data, input logic ackv,
                          input int extra, input int intrude);
    int n;
    n = cmd_ticks(c) + extra;
    send_item(make_req(c, data, ackv, 1'($urandom)));
    for (int k = 1; k <= n; k++) begin
      if (k == intrude)
        send_item(make_req(3'($urandom_range(int'(CMD_START), int'(CMD_RACK))),
                           8'($urandom), 1'($urandom), 1'($urandom)));
      send_item(random_tick());
    end
  endtask

  // Brings the engine to idle and waits for every response before the
  // registers may be touched.
  task automatic settle(input int drain_ticks);
    for (int k = 0; k < drain_ticks; k++) send_item(random_tick());
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_SLOT_TICKS: slot_now = val;
      CFG_LEAD_LOW:   lead_now = val[0];
      default: ;
    endcase
  endtask

  task automatic random_command();
    cmd_t c;
    int   n;
    int   extra;
    int   intrude;
    c = cmd_t'($urandom_range(int'(CMD_START), int'(CMD_RACK)));
    n = cmd_ticks(c);
    extra = $urandom_range(0, 3);
    if ($urandom_range(0, 11) == 0) extra = -int'($urandom_range(1, n));
    intrude = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : 0;
    play_cmd(c, 8'($urandom), 1'($urandom), extra, intrude);
  endtask

  initial begin : stimulus
    int phase_start;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ticks while idle, including the unused request code, change nothing.
    send_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0));
    send_item(make_req(REQ_TICK_ALT, 8'hFF, 1'b1, 1'b1));
    // Reset timing: five ticks per slot with the leading SCL-low slot.
    play_cmd(CMD_START, 8'h00, 1'b0, 0, 0);
    settle(0);
    write_reg(CFG_SLOT_TICKS, '0);
    write_reg(CFG_UNUSED, '1);
    play_cmd(CMD_WRITE, 8'hFF, 1'b0, 0, 0);
    play_cmd(CMD_WRITE, 8'h00, 1'b1, 0, 5);
    play_cmd(CMD_READ, 8'h5A, 1'b0, 0, 0);
    play_cmd(CMD_SACK, 8'h00, 1'b1, 0, 0);
    play_cmd(CMD_SACK, 8'hFF, 1'b0, 0, 0);
    play_cmd(CMD_RACK, 8'hA5, 1'b1, 0, 0);
    play_cmd(CMD_STOP, 8'h00, 1'b0, 0, 0);
    settle(0);
    write_reg(CFG_LEAD_LOW, '0);
    play_cmd(CMD_START, 8'h00, 1'b0, 0, 0);
    play_cmd(CMD_STOP, 8'hFF, 1'b1, 0, 0);

    for (int p = 0; p < N_PHASES; p++) begin
      settle(cmd_ticks(CMD_WRITE) + 2);
      write_reg(CFG_SLOT_TICKS, CFG_DATA_W'(slot_plan[p]));
      write_reg(CFG_LEAD_LOW, {CFG_DATA_W'($urandom)} ^ CFG_DATA_W'(p % 2 == 0));
      // The receiver holds off while requests keep coming, filling the block.
      if (p == 0 || p == 3) hold_asks++;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_command();
    end

    // Largest slot length: only the opening of one start fits in the run.
    settle(cmd_ticks(CMD_WRITE) + 2);
    write_reg(CFG_SLOT_TICKS, '1);
    write_reg(CFG_LEAD_LOW, {CFG_DATA_W'($urandom)} | CFG_DATA_W'(1));
    play_cmd(CMD_START, 8'h00, 1'b0, 20 - cmd_ticks(CMD_START), 7);
    send_item(make_req(CMD_STOP, 8'hFF, 1'b1, 1'b1));
    send_item(random_tick());

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/i2cmb_pkg.sv
src/i2cmb_front.sv
src/i2cmb_back.sv
src/i2c_master_bit_engine.sv
sim/i2cmb_bus_checker.sv
sim/tb_i2c_master_bit_engine.sv
